[design/lr_pkg.sv]
`default_nettype none
package lr_pkg;
  localparam int COORD_BITS = 12;
  localparam int COLOR_BITS = 24;

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_NEXT  = 1'b1;

  localparam logic [1:0] OCT_SHALLOW_UP = 2'd0;
  localparam logic [1:0] OCT_STEEP_UP   = 2'd1;
  localparam logic [1:0] OCT_SHALLOW_DN = 2'd2;
  localparam logic [1:0] OCT_STEEP_DN   = 2'd3;
endpackage
`default_nettype wire

[design/lr_in_if.sv]
`default_nettype none
interface lr_in_if #(
  parameter int COORD_BITS = lr_pkg::COORD_BITS
);
  logic                                valid;
  logic                                ready;
  logic                                mode;
  logic signed [COORD_BITS-1:0]        start_x;
  logic signed [COORD_BITS-1:0]        start_y;
  logic signed [COORD_BITS-1:0]        end_x_in;
  logic signed [COORD_BITS-1:0]        end_y_in;
  logic        [lr_pkg::COLOR_BITS-1:0] pen_color;

  modport source (output valid, mode, start_x, start_y, end_x_in, end_y_in, pen_color,
                  input ready);
  modport sink   (input valid, mode, start_x, start_y, end_x_in, end_y_in, pen_color,
                  output ready);
endinterface
`default_nettype wire

[design/lr_out_if.sv]
`default_nettype none
interface lr_out_if #(
  parameter int COORD_BITS = lr_pkg::COORD_BITS
);
  logic                                valid;
  logic                                ready;
  logic signed [COORD_BITS-1:0]        pixel_x;
  logic signed [COORD_BITS-1:0]        pixel_y;
  logic        [lr_pkg::COLOR_BITS-1:0] pixel_color;
  logic                                last_pixel;
  logic                                pixel_valid;

  modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel, pixel_valid,
                  input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_color, last_pixel, pixel_valid,
                  output ready);
endinterface
`default_nettype wire

[design/line_rasterizer_unit.sv]
`default_nettype none
// Midpoint line rasterizer, one pixel per request. A start request (mode 0) loads two
// endpoints and a color and yields the first pixel; each next request (mode 1) yields
// the following pixel, last_pixel marks the end of the line, and a next request with no
// line in progress yields pixel_valid 0 with all other fields zero. A start request
// abandons any line in progress. Requests are taken every clock while the consumer takes
// results: a setup register (endpoint ordering, deltas, octant and error term, independent
// of the running line) feeds a single step stage (one add and compare on the error term)
// into the result register, so the sustained rate is one pixel per clock while the
// consumer takes results.
module line_rasterizer_unit #(
  parameter int COORD_BITS = lr_pkg::COORD_BITS
) (
  input  wire logic clk,
  input  wire logic rst,
  lr_in_if.sink     req,
  lr_out_if.source  pix
);
  localparam int W = COORD_BITS + 5;
  localparam int CB = lr_pkg::COLOR_BITS;
  localparam logic signed [COORD_BITS-1:0] ONE = COORD_BITS'(1);

  // setup stage
  logic                   s1_valid;
  logic                   s1_mode;
  logic signed [COORD_BITS-1:0] s1_x, s1_y, s1_stop_x, s1_stop_y;
  logic signed [W-1:0]    s1_dec, s1_step_a, s1_step_b;
  logic [1:0]             s1_oct;
  logic [CB-1:0]          s1_color;

  // line state
  logic                   line_active;
  logic signed [COORD_BITS-1:0] cur_x, cur_y, stop_x, stop_y;
  logic signed [W-1:0]    decision, step_a, step_b;
  logic [1:0]             octant_case;
  logic [CB-1:0]          held_color;

  // result register
  logic                   res_valid;
  logic signed [COORD_BITS-1:0] res_x, res_y;
  logic [CB-1:0]          res_color;
  logic                   res_last, res_px;

  logic advance;
  assign advance   = !res_valid || pix.ready;
  assign req.ready = !s1_valid || advance;

  // setup logic
  logic                   swap;
  logic signed [COORD_BITS-1:0] a_x, a_y, b_x, b_y;
  logic signed [W-1:0]    dx, dy, ady, tdx, tdy;
  logic [1:0]             oct_set;
  logic signed [W-1:0]    dec_set, sa_set, sb_set;

  always_comb begin
    swap = req.start_x > req.end_x_in;
    a_x  = swap ? req.end_x_in : req.start_x;
    a_y  = swap ? req.end_y_in : req.start_y;
    b_x  = swap ? req.start_x  : req.end_x_in;
    b_y  = swap ? req.start_y  : req.end_y_in;
    dx   = W'(b_x) - W'(a_x);
    dy   = W'(b_y) - W'(a_y);
    ady  = (dy < 0) ? -dy : dy;
    tdx  = dx <<< 1;
    tdy  = dy <<< 1;
    if (dy > 0) begin
      oct_set = (dx > dy) ? lr_pkg::OCT_SHALLOW_UP : lr_pkg::OCT_STEEP_UP;
    end else begin
      oct_set = (dx > ady) ? lr_pkg::OCT_SHALLOW_DN : lr_pkg::OCT_STEEP_DN;
    end
    case (oct_set)
      lr_pkg::OCT_SHALLOW_UP: begin
        dec_set = tdy - dx;
        sa_set  = tdy;
        sb_set  = tdy - tdx;
      end
      lr_pkg::OCT_STEEP_UP: begin
        dec_set = dy - tdx;
        sa_set  = -tdx;
        sb_set  = tdy - tdx;
      end
      lr_pkg::OCT_SHALLOW_DN: begin
        dec_set = tdy + dx;
        sa_set  = tdy;
        sb_set  = tdy + tdx;
      end
      default: begin
        dec_set = dy + tdx;
        sa_set  = tdx;
        sb_set  = tdy + tdx;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
    if (req.valid && req.ready) begin
      s1_mode   <= req.mode;
      s1_x      <= a_x;
      s1_y      <= a_y;
      s1_stop_x <= b_x;
      s1_stop_y <= b_y;
      s1_dec    <= dec_set;
      s1_step_a <= sa_set;
      s1_step_b <= sb_set;
      s1_oct    <= oct_set;
      s1_color  <= req.pen_color;
    end
  end

  // step logic
  logic                   w_start, w_active;
  logic signed [COORD_BITS-1:0] w_x, w_y, w_stop_x, w_stop_y;
  logic signed [W-1:0]    w_dec, w_sa, w_sb;
  logic [1:0]             w_oct;
  logic [CB-1:0]          w_color;
  logic                   is_last, take_a;
  logic signed [COORD_BITS-1:0] x_next, y_next;
  logic signed [W-1:0]    dec_next;

  always_comb begin
    w_start  = s1_mode == lr_pkg::MODE_START;
    w_active = w_start || line_active;
    w_x      = w_start ? s1_x      : cur_x;
    w_y      = w_start ? s1_y      : cur_y;
    w_stop_x = w_start ? s1_stop_x : stop_x;
    w_stop_y = w_start ? s1_stop_y : stop_y;
    w_dec    = w_start ? s1_dec    : decision;
    w_sa     = w_start ? s1_step_a : step_a;
    w_sb     = w_start ? s1_step_b : step_b;
    w_oct    = w_start ? s1_oct    : octant_case;
    w_color  = w_start ? s1_color  : held_color;
    x_next   = w_x;
    y_next   = w_y;
    case (w_oct)
      lr_pkg::OCT_SHALLOW_UP: begin
        is_last = w_x == w_stop_x;
        take_a  = w_dec < 0;
        x_next  = w_x + ONE;
        if (!take_a) y_next = w_y + ONE;
      end
      lr_pkg::OCT_STEEP_UP: begin
        is_last = w_y == w_stop_y;
        take_a  = w_dec > 0;
        y_next  = w_y + ONE;
        if (!take_a) x_next = w_x + ONE;
      end
      lr_pkg::OCT_SHALLOW_DN: begin
        is_last = w_x == w_stop_x;
        take_a  = w_dec > 0;
        x_next  = w_x + ONE;
        if (!take_a) y_next = w_y - ONE;
      end
      default: begin
        is_last = w_y == w_stop_y;
        take_a  = w_dec < 0;
        y_next  = w_y - ONE;
        if (!take_a) x_next = w_x + ONE;
      end
    endcase
    dec_next = w_dec + (take_a ? w_sa : w_sb);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid   <= 1'b0;
      line_active <= 1'b0;
    end else if (advance) begin
      res_valid <= s1_valid;
      if (s1_valid && w_active) begin
        line_active <= !is_last;
      end
    end
    if (advance && s1_valid) begin
      res_px    <= w_active;
      res_last  <= w_active && is_last;
      res_x     <= w_active ? w_x : '0;
      res_y     <= w_active ? w_y : '0;
      res_color <= w_active ? w_color : '0;
      if (w_active) begin
        cur_x       <= x_next;
        cur_y       <= y_next;
        stop_x      <= w_stop_x;
        stop_y      <= w_stop_y;
        decision    <= dec_next;
        step_a      <= w_sa;
        step_b      <= w_sb;
        octant_case <= w_oct;
        held_color  <= w_color;
      end
    end
  end

  assign pix.valid       = res_valid;
  assign pix.pixel_x     = res_x;
  assign pix.pixel_y     = res_y;
  assign pix.pixel_color = res_color;
  assign pix.last_pixel  = res_last;
  assign pix.pixel_valid = res_px;

  a_last_is_pixel: assert property (@(posedge clk) disable iff (rst)
    pix.valid && pix.last_pixel |-> pix.pixel_valid)
    else $error("last_pixel without pixel_valid");

  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    pix.valid && !pix.pixel_valid |->
      pix.pixel_x == '0 && pix.pixel_y == '0 && pix.pixel_color == '0)
    else $error("idle result carries nonzero fields");

  a_last_ends_line: assert property (@(posedge clk) disable iff (rst)
    advance && s1_valid && w_active && is_last |=> !line_active)
    else $error("line still active after its last pixel");

  a_start_activates: assert property (@(posedge clk) disable iff (rst)
    advance && s1_valid && w_start && !is_last |=> line_active)
    else $error("start request did not open a line");
endmodule
`default_nettype wire
